// File: rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// NTC conversion package
// Shared widths, status and register codes, and the thermistor curve table.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int ADC_W      = 10;
    localparam int TEMP_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Entries of the curve that the lookup uses, clamped to at least two and to what the table holds.
    localparam int TABLE_ENTRIES = 36;
    localparam int CURVE_HELD    = 36;
    localparam int CURVE_USED    = (TABLE_ENTRIES > CURVE_HELD) ? CURVE_HELD :
                                   (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
    localparam int SEG_W         = $clog2(CURVE_USED);

    localparam int FIRST_TEMP = -50;
    localparam int STEP_TEMP  = 5;
    localparam int ADC_FULL   = 1023;

    // Working width for temperature sums before they are cut to TEMP_W.
    localparam int TEMP_CALC_W = 10;

    localparam logic [TEMP_W-1:0] TEMP_BELOW = TEMP_W'(FIRST_TEMP - 1);
    localparam logic [TEMP_W-1:0] TEMP_ABOVE =
        TEMP_W'(FIRST_TEMP + STEP_TEMP * (CURVE_USED - 1) + 1);

    localparam logic [ADC_W-1:0] SHORT_LIMIT_RESET = 10'd8;
    localparam logic [ADC_W-1:0] OPEN_LIMIT_RESET  = 10'd1016;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_OPEN  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_LIMIT = 2'd0,
        REG_OPEN_LIMIT  = 2'd1
    } reg_index_t;

    // Inverted divider reading at each 5 degree point, from -50 C upward.
    localparam logic [ADC_W-1:0] NTC_CURVE [CURVE_HELD] = '{
        10'd26,  10'd34,  10'd46,  10'd60,  10'd77,  10'd98,  10'd124, 10'd153,
        10'd187, 10'd226, 10'd268, 10'd314, 10'd362, 10'd412, 10'd462, 10'd512,
        10'd560, 10'd606, 10'd650, 10'd690, 10'd727, 10'd760, 10'd790, 10'd817,
        10'd841, 10'd862, 10'd881, 10'd897, 10'd912, 10'd925, 10'd936, 10'd945,
        10'd954, 10'd961, 10'd968, 10'd974
    };

    // Curve point lookup; an index past the used entries returns the last one.
    function automatic logic [ADC_W-1:0] curve_at(input logic [SEG_W-1:0] idx);
        logic [ADC_W-1:0] point;
        point = NTC_CURVE[CURVE_USED-1];
        if (int'(idx) < CURVE_USED)
        begin
            point = NTC_CURVE[idx];
        end
        return point;
    endfunction

endpackage

// File: rtl/ntc_sample_if.sv
// ----------------------------------------------------------------------------
// NTC sample channel
// Valid/ready channel carrying one raw converter reading per beat.
// ----------------------------------------------------------------------------
interface ntc_sample_if
    import ntc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

// File: rtl/ntc_result_if.sv
// ----------------------------------------------------------------------------
// NTC result channel
// Valid/ready channel carrying sensor status and temperature per beat.
// ----------------------------------------------------------------------------
interface ntc_result_if
    import ntc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] sensor_status;
    logic [TEMP_W-1:0]   temperature_c;

    modport source (output valid, output sensor_status, output temperature_c, input ready);
    modport sink   (input valid, input sensor_status, input temperature_c, output ready);
endinterface

// File: rtl/ntc_cfg_if.sv
// ----------------------------------------------------------------------------
// NTC configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ntc_cfg_if
    import ntc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: rtl/ntc_adc_to_temperature_unit.sv
// ----------------------------------------------------------------------------
// NTC ADC to temperature unit
// Converts a thermistor divider reading into a status and a temperature in
// degrees C by a piecewise-linear lookup over a constant curve.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload                        | Beat
//  --------+-----------+--------------------------------+-----------------------
//  sample  | in        | adc_sample[9:0]                | one reading
//  result  | out       | sensor_status[1:0], temp[7:0]  | one result per reading
//  cfg     | in        | reg_index[1:0], wdata[9:0]     | one register write
//
// The unit is a four stage pipeline and takes one beat per cycle unless a
// held output backs up into stage 1; results leave from the stage 4 register.
// Stage 1 checks the fault limits and inverts the reading, stage 2 compares
// it against every curve point in parallel, stage 3 fetches the enclosing
// points and scales the offset, and stage 4 runs a three step divider and is
// the output register. Each stage moves when it is empty or when the stage
// after it moves, so bubbles close up and a held output does not stop input
// while an earlier stage is empty. Reset clears all stage valid bits and
// loads the limits with their defaults. The cfg channel is always ready.
//
module ntc_adc_to_temperature_unit
    import ntc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ntc_sample_if.sink    sample,
    ntc_result_if.source  result,
    ntc_cfg_if.sink       cfg
);

    localparam int NUM_W = ADC_W + 3;

    // Configuration registers.
    logic [ADC_W-1:0] short_limit_reg;
    logic [ADC_W-1:0] open_limit_reg;

    // Stage valid bits and their enables.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_en, s2_en, s3_en, s4_en;

    // Stage 1: status and inverted reading.
    status_t          s1_status_reg, s1_status_next;
    logic [ADC_W-1:0] s1_inv_reg, s1_inv_next;

    // Stage 2: curve segment and out of range flags.
    status_t          s2_status_reg;
    logic [ADC_W-1:0] s2_inv_reg;
    logic [SEG_W-1:0] s2_seg_reg, s2_seg_next;
    logic             s2_below_reg, s2_below_next;
    logic             s2_above_reg, s2_above_next;

    // Stage 3: scaled offset, segment span and segment base temperature.
    status_t                s3_status_reg;
    logic                   s3_below_reg, s3_above_reg;
    logic [NUM_W-1:0]       s3_num_reg, s3_num_next;
    logic [ADC_W-1:0]       s3_span_reg, s3_span_next;
    logic [TEMP_CALC_W-1:0] s3_base_reg, s3_base_next;

    // Stage 4: output register.
    status_t           s4_status_reg, s4_status_next;
    logic [TEMP_W-1:0] s4_temp_reg, s4_temp_next;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    assign s4_en = !s4_valid_reg || result.ready;
    assign s3_en = !s3_valid_reg || s4_en;
    assign s2_en = !s2_valid_reg || s3_en;
    assign s1_en = !s1_valid_reg || s2_en;

    assign sample.ready = s1_en;
    assign cfg.ready    = 1'b1;

    assign result.valid         = s4_valid_reg;
    assign result.sensor_status = s4_status_reg;
    assign result.temperature_c = s4_temp_reg;

    // ------------------------------------------------------------------
    // Stage 1 logic: the short test comes first so it wins when the two
    // limits cross.
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_status_next = STATUS_OK;
        if (sample.adc_sample < short_limit_reg)
        begin
            s1_status_next = STATUS_SHORT;
        end
        else if (sample.adc_sample > open_limit_reg)
        begin
            s1_status_next = STATUS_OPEN;
        end
        s1_inv_next = ADC_W'(ADC_FULL) - sample.adc_sample;
    end

    // ------------------------------------------------------------------
    // Stage 2 logic: the curve rises strictly, so the compares form a
    // thermometer code and the highest point passed names the segment.
    // ------------------------------------------------------------------
    always_comb
    begin
        s2_seg_next = '0;
        for (int j = 1; j < CURVE_USED; j++)
        begin
            if (s1_inv_reg >= NTC_CURVE[j])
            begin
                s2_seg_next = SEG_W'(j);
            end
        end
        s2_below_next = s1_inv_reg < NTC_CURVE[0];
        s2_above_next = s1_inv_reg >= NTC_CURVE[CURVE_USED-1];
    end

    // ------------------------------------------------------------------
    // Stage 3 logic: offset into the segment times five, the segment span,
    // and the temperature at the segment's lower point.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [ADC_W-1:0] lo;
        logic [ADC_W-1:0] hi;
        logic [ADC_W-1:0] diff;
        lo   = curve_at(s2_seg_reg);
        hi   = curve_at(s2_seg_reg + SEG_W'(1));
        diff = s2_inv_reg - lo;
        s3_num_next  = {1'b0, diff, 2'b00} + NUM_W'(diff);
        s3_span_next = hi - lo;
        s3_base_next = TEMP_CALC_W'(FIRST_TEMP)
                     + TEMP_CALC_W'({s2_seg_reg, 2'b00})
                     + TEMP_CALC_W'(s2_seg_reg);
    end

    // ------------------------------------------------------------------
    // Stage 4 logic: floor divide by the span. The offset lies below the
    // span, so the quotient is below five and three restoring steps do it.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [NUM_W-1:0]       rem;
        logic [NUM_W-1:0]       trial;
        logic [2:0]             frac;
        logic [TEMP_CALC_W-1:0] temp_sum;
        rem  = s3_num_reg;
        frac = '0;
        for (int b = 2; b >= 0; b--)
        begin
            trial = NUM_W'(s3_span_reg) << b;
            if (rem >= trial)
            begin
                rem     = rem - trial;
                frac[b] = 1'b1;
            end
        end
        temp_sum = s3_base_reg + TEMP_CALC_W'(frac);

        s4_status_next = s3_status_reg;
        if (s3_status_reg != STATUS_OK)
        begin
            s4_temp_next = '0;
        end
        else if (s3_below_reg)
        begin
            s4_temp_next = TEMP_BELOW;
        end
        else if (s3_above_reg)
        begin
            s4_temp_next = TEMP_ABOVE;
        end
        else
        begin
            s4_temp_next = temp_sum[TEMP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Control state: valid bits and configuration registers. Writes to an
    // index outside the register list are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            short_limit_reg <= SHORT_LIMIT_RESET;
            open_limit_reg  <= OPEN_LIMIT_RESET;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (cfg.valid)
            begin
                unique case (cfg.reg_index)
                    REG_SHORT_LIMIT: short_limit_reg <= cfg.wdata;
                    REG_OPEN_LIMIT:  open_limit_reg  <= cfg.wdata;
                    default:         ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers, loaded with their stage and never reset.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_status_reg <= s1_status_next;
            s1_inv_reg    <= s1_inv_next;
        end
        if (s2_en)
        begin
            s2_status_reg <= s1_status_reg;
            s2_inv_reg    <= s1_inv_reg;
            s2_seg_reg    <= s2_seg_next;
            s2_below_reg  <= s2_below_next;
            s2_above_reg  <= s2_above_next;
        end
        if (s3_en)
        begin
            s3_status_reg <= s2_status_reg;
            s3_below_reg  <= s2_below_reg;
            s3_above_reg  <= s2_above_reg;
            s3_num_reg    <= s3_num_next;
            s3_span_reg   <= s3_span_next;
            s3_base_reg   <= s3_base_next;
        end
        if (s4_en)
        begin
            s4_status_reg <= s4_status_next;
            s4_temp_reg   <= s4_temp_next;
        end
    end

endmodule

// File: tb/ntc_adc_to_temperature_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NTC ADC to temperature unit testbench
// Streams converter readings through the unit under several limit settings,
// predicts each status and temperature from an independent curve lookup and
// checks every result beat in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature_unit_tb;

    import ntc_pkg::*;

    // Clock period and the hard stop for a run that hangs.
    localparam int CLK_PERIOD  = 10;
    localparam int RUN_LIMIT   = 5_000_000;

    // The pipeline is four stages deep; this is the settle time at the end.
    localparam int DRAIN_CYCLES = 12;

    // Readings in each randomized phase.
    localparam int PHASE_READINGS = 320;

    // The long output hold-off starts once this many readings went in.
    localparam int HOLD_AFTER  = 500;
    localparam int HOLD_CYCLES = 300;

    // Register indexes that decode to nothing and must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Inverted divider reading at each 5 degree point from -50 C upward.
    // Kept here on its own so that a bad table in the design shows up.
    localparam int CURVE_POINTS = 36;
    localparam int CURVE_IN_USE = (TABLE_ENTRIES > CURVE_POINTS) ? CURVE_POINTS :
                                  (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
    localparam int THERMISTOR_CURVE [CURVE_POINTS] = '{
         26,  34,  46,  60,  77,  98, 124, 153, 187, 226, 268, 314,
        362, 412, 462, 512, 560, 606, 650, 690, 727, 760, 790, 817,
        841, 862, 881, 897, 912, 925, 936, 945, 954, 961, 968, 974
    };

    // Readings that sit on the fault limits, the curve ends, exact curve
    // points and alternating bit patterns, for the default limits.
    localparam int EDGE_COUNT = 20;
    localparam logic [ADC_W-1:0] EDGE_READINGS [EDGE_COUNT] = '{
        10'd0,   10'd7,   10'd8,   10'd9,   10'd48,  10'd49,  10'd50,
        10'd463, 10'd511, 10'd512, 10'd341, 10'd682, 10'd996, 10'd997,
        10'd998, 10'd1015, 10'd1016, 10'd1017, 10'd1022, 10'd1023
    };

    typedef struct packed {
        status_t                  status;
        logic signed [TEMP_W-1:0] temp;
    } conversion_t;

    logic clk;
    logic rst_n;

    ntc_sample_if sample_ch ();
    ntc_result_if result_ch ();
    ntc_cfg_if    cfg_ch ();

    ntc_adc_to_temperature_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Readings waiting to be offered, and conversions waiting to come out.
    logic [ADC_W-1:0] readings_q [$];
    conversion_t      conversions_q [$];

    // The limits as the unit should hold them. They only change while the
    // unit is empty, so a reading is judged by the values at its beat.
    logic [ADC_W-1:0] short_lim = SHORT_LIMIT_RESET;
    logic [ADC_W-1:0] open_lim  = OPEN_LIMIT_RESET;

    bit no_idle = 1'b0;
    int mismatches = 0;
    int readings_taken;
    int gap_left;
    int stall_left;
    int hold_left;
    bit hold_armed;

    // Status and temperature for one reading. Faults win over the lookup,
    // and the short test is made first, so crossed limits report shorts.
    // A valid reading is inverted and interpolated between the two curve
    // points around it with floor division; off the curve it clamps to one
    // degree below the first point or one above the last point in use.
    function automatic conversion_t convert_reading(input logic [ADC_W-1:0] adc);
        conversion_t conv;
        int          inv;
        int          deg;
        int          seg;
        conv.status = STATUS_OK;
        conv.temp   = '0;
        if (adc < short_lim)
        begin
            conv.status = STATUS_SHORT;
        end
        else if (adc > open_lim)
        begin
            conv.status = STATUS_OPEN;
        end
        else
        begin
            inv = ADC_FULL - int'(adc);
            deg = 0;
            if (inv < THERMISTOR_CURVE[0])
            begin
                deg = FIRST_TEMP - 1;
            end
            else if (inv >= THERMISTOR_CURVE[CURVE_IN_USE-1])
            begin
                deg = FIRST_TEMP + STEP_TEMP * (CURVE_IN_USE - 1) + 1;
            end
            else
            begin
                for (seg = 0; seg < CURVE_IN_USE - 1; seg++)
                begin
                    if (inv >= THERMISTOR_CURVE[seg] && inv < THERMISTOR_CURVE[seg+1])
                    begin
                        deg = FIRST_TEMP + seg * STEP_TEMP +
                              ((inv - THERMISTOR_CURVE[seg]) * STEP_TEMP) /
                              (THERMISTOR_CURVE[seg+1] - THERMISTOR_CURVE[seg]);
                    end
                end
            end
            conv.temp = TEMP_W'(deg);
        end
        return conv;
    endfunction

    // Clock generator.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the unit stops moving beats.
    initial
    begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Sample driver. At each edge it first notes an accepted beat and
    // predicts its result, then offers the next queued reading unless an
    // idle burst is running. Valid is assigned once per edge at most.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid      <= 1'b0;
            sample_ch.adc_sample <= '0;
            gap_left             <= 0;
            readings_taken       <= 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                conversions_q.push_back(convert_reading(sample_ch.adc_sample));
                readings_taken <= readings_taken + 1;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left        <= gap_left - 1;
                    sample_ch.valid <= 1'b0;
                end
                else if (readings_q.size() != 0)
                begin
                    sample_ch.valid      <= 1'b1;
                    sample_ch.adc_sample <= readings_q.pop_front();
                    // Now and then an idle burst follows this beat.
                    if (!no_idle && $urandom_range(0, 9) == 0)
                    begin
                        gap_left <= $urandom_range(1, 16);
                    end
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off on the result side, started once enough readings
    // went in. The sender keeps offering meanwhile, so the pipeline fills
    // and the unit has to push back on its sample input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && readings_taken >= HOLD_AFTER)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor. Each accepted beat is matched against the oldest
    // predicted conversion; ready drops for random stall bursts and for
    // the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        conversion_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (conversions_q.size() == 0)
                begin
                    $error("result beat with nothing pending: sensor_status %0d temperature_c %0d",
                           result_ch.sensor_status, $signed(result_ch.temperature_c));
                    mismatches++;
                end
                else
                begin
                    want = conversions_q.pop_front();
                    if (result_ch.sensor_status !== want.status)
                    begin
                        $error("sensor_status: expected %0d, actual %0d",
                               want.status, result_ch.sensor_status);
                        mismatches++;
                    end
                    if (result_ch.temperature_c !== want.temp)
                    begin
                        $error("temperature_c: expected %0d, actual %0d",
                               want.temp, $signed(result_ch.temperature_c));
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left      <= stall_left - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 11) == 0)
            begin
                // Ready drops here and stays low while the drawn stall count runs down.
                stall_left      <= $urandom_range(0, 15);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // One register write on the cfg channel, then the local copy follows.
    // Spare indexes leave both limits as they were.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        if (idx == REG_SHORT_LIMIT)
        begin
            short_lim = val;
        end
        else if (idx == REG_OPEN_LIMIT)
        begin
            open_lim = val;
        end
    endtask

    // Waits on falling edges, after the driver has had its turn, until no
    // reading is queued or on the wire and every conversion has come out.
    task automatic wait_drained();
        @(negedge clk);
        while (readings_q.size() != 0 || sample_ch.valid || conversions_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Queues a batch of random readings. Most are uniform; the rest land
    // right around curve points and around the current fault limits, where
    // off-by-one errors in the compares would show.
    task automatic queue_random_readings(input int count);
        int n;
        int pick;
        int v;
        @(negedge clk);
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
            begin
                v = $urandom_range(0, ADC_FULL);
            end
            else if (pick < 17)
            begin
                v = ADC_FULL - THERMISTOR_CURVE[$urandom_range(0, CURVE_POINTS - 1)]
                    + int'($urandom_range(0, 2)) - 1;
            end
            else if (pick < 19)
            begin
                v = int'(short_lim) + int'($urandom_range(0, 2)) - 1;
            end
            else
            begin
                v = int'(open_lim) + int'($urandom_range(0, 2)) - 1;
            end
            if (v < 0)
            begin
                v = 0;
            end
            if (v > ADC_FULL)
            begin
                v = ADC_FULL;
            end
            readings_q.push_back(ADC_W'(v));
        end
    endtask

    // Test sequence. Reset once, a directed pass on the reset limits, then
    // randomized phases under different limit settings, each written while
    // the unit is empty. The last phase runs with no idling on either side.
    initial
    begin
        int k;
        rst_n            <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.reg_index <= REG_SHORT_LIMIT;
        cfg_ch.wdata     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed readings against the reset limits: both fault edges,
        // both ends of the curve, exact curve points and bit patterns.
        @(negedge clk);
        for (k = 0; k < EDGE_COUNT; k++)
        begin
            readings_q.push_back(EDGE_READINGS[k]);
        end
        wait_drained();

        // Writes to the spare indexes must not touch either limit.
        write_reg(REG_SPARE_A, 10'h3FF);
        write_reg(REG_SPARE_B, 10'h000);
        queue_random_readings(PHASE_READINGS);
        wait_drained();

        // Widest window: no faults at all, the whole curve reachable.
        write_reg(REG_SHORT_LIMIT, 10'd0);
        write_reg(REG_OPEN_LIMIT, 10'd1023);
        queue_random_readings(PHASE_READINGS);
        wait_drained();

        // Crossed limits: the short test wins, only full scale reads open.
        write_reg(REG_SHORT_LIMIT, 10'd1023);
        write_reg(REG_OPEN_LIMIT, 10'd0);
        queue_random_readings(PHASE_READINGS);
        wait_drained();

        // A narrow window in the middle, alternating bit patterns.
        write_reg(REG_SHORT_LIMIT, 10'h155);
        write_reg(REG_OPEN_LIMIT, 10'h2AA);
        queue_random_readings(PHASE_READINGS);
        wait_drained();

        // Random limits near the usual places.
        write_reg(REG_SHORT_LIMIT, CFG_DATA_W'($urandom_range(0, 60)));
        write_reg(REG_OPEN_LIMIT, CFG_DATA_W'($urandom_range(960, 1023)));
        queue_random_readings(PHASE_READINGS);
        wait_drained();

        // Back to the reset limits, full rate on both sides.
        write_reg(REG_SHORT_LIMIT, SHORT_LIMIT_RESET);
        write_reg(REG_OPEN_LIMIT, OPEN_LIMIT_RESET);
        no_idle <= 1'b1;
        queue_random_readings(PHASE_READINGS);
        wait_drained();

        // Give a stray extra beat the chance to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/ntc_pkg.sv
rtl/ntc_sample_if.sv
rtl/ntc_result_if.sv
rtl/ntc_cfg_if.sv
rtl/ntc_adc_to_temperature_unit.sv
tb/ntc_adc_to_temperature_unit_tb.sv
